/* rtl/psq_pkg.sv */
// shared types and constants of the priority sleep queue
// no dependencies; used by priority_sleep_queue_top and the testbench
package psq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_BITS     = 8;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PORT_ID_W = 8;
  localparam int unsigned PRI_W    = 6;
  localparam int unsigned STATUS_W = 2;

  localparam logic [PRI_W-1:0] MAX_PRIORITY = PRI_W'(48);

  localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAKE_ONE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WAKE_ALL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_QUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_WOKEN  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [PORT_ID_W-1:0] waiter_id;
    logic [PRI_W-1:0]     priority_req;
    logic                 interruptible;
  } psq_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [PORT_ID_W-1:0] woken_id;
    logic [PRI_W-1:0]     woken_priority;
    logic                 woken_interruptible;
    logic                 last;
  } psq_out_t;

endpackage

/* rtl/psq_store.sv */
// entry storage of the priority sleep queue: one write port, one read port
// with registered read data; depends on nothing
module psq_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/priority_sleep_queue_top.sv */
// priority sleep queue: entries kept in descending priority, fifo among equals
// after an accepted transaction in_ready_o stays low while it is processed: an insert
// reads and shifts back each lower priority entry in turn, a wake-all hands out one
// result per entry, an ignored mode leaves it high, receiver stalls lengthen it; the pace is
// set by the single memory read port; the last result is valid as in_ready_o returns
// reset (rst_ni low) empties the queue at once; entry storage is not cleared
module priority_sleep_queue_top #(
  parameter int unsigned QUEUE_DEPTH = psq_pkg::QUEUE_DEPTH,
  parameter int unsigned ID_BITS     = psq_pkg::ID_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  psq_pkg::psq_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output psq_pkg::psq_out_t out_data_o
);

  import psq_pkg::*;

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRY_W = ID_BITS + PRI_W + 1;
  // id bits that survive between the port width and the stored width
  localparam int unsigned KEEP_W  = (ID_BITS < PORT_ID_W) ? ID_BITS : PORT_ID_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RESP    = 3'd1;  // single status-only result
  localparam logic [2:0] ST_INS_CHK = 3'd2;  // decide: place new entry or read the one ahead
  localparam logic [2:0] ST_INS_CMP = 3'd3;  // compare the read entry, shift it back or stop
  localparam logic [2:0] ST_W1_OUT  = 3'd4;  // head entry read, hand it out
  localparam logic [2:0] ST_WA_RD   = 3'd5;  // wake-all: read next entry
  localparam logic [2:0] ST_WA_OUT  = 3'd6;  // wake-all: hand entry out

  logic [2:0]          state_q, state_d;
  logic [PTR_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [ENTRY_W-1:0]  new_q, new_d;

  logic     out_valid_q, out_valid_d;
  psq_out_t out_q, out_d;

  // memory port signals
  logic               mem_we, mem_re;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

  // shared unit: circular address adder and priority compare
  logic [CNT_W-1:0] offset;
  logic [PTR_W:0]   addr_sum;
  logic [PTR_W-1:0] phys_addr;
  logic             rd_lower;

  logic [PRI_W-1:0] req_pri;
  logic             out_free;
  logic             wa_last;

  logic [ID_BITS-1:0] rd_id;
  logic [PRI_W-1:0]   rd_pri;
  logic               rd_flg;

  assign rd_id  = mem_rdata[ENTRY_W-1 -: ID_BITS];
  assign rd_pri = mem_rdata[PRI_W:1];
  assign rd_flg = mem_rdata[0];

  // head plus logical offset, wrapped into the ring
  assign addr_sum  = {1'b0, head_q} + {1'b0, offset[PTR_W-1:0]};
  assign phys_addr = (addr_sum >= (PTR_W+1)'(QUEUE_DEPTH))
                   ? PTR_W'(addr_sum - (PTR_W+1)'(QUEUE_DEPTH))
                   : addr_sum[PTR_W-1:0];
  // the new entry goes ahead of the first strictly lower priority, so we shift
  // back only those
  assign rd_lower  = rd_pri < new_q[PRI_W:1];

  assign req_pri  = (in_data_i.priority_req > MAX_PRIORITY) ? MAX_PRIORITY
                                                            : in_data_i.priority_req;
  assign out_free = !out_valid_q || out_ready_i;
  assign wa_last  = (idx_q + CNT_W'(1)) == count_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    status_d    = status_q;
    new_d       = new_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    offset      = idx_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wdata   = new_q;

    unique case (state_q)
      ST_IDLE: begin
        offset = '0;
        if (in_valid_i) begin
          unique case (in_data_i.mode)
            MODE_INSERT: begin
              if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                status_d = STATUS_FULL;
                state_d  = ST_RESP;
              end else begin
                new_d   = {ID_BITS'(in_data_i.waiter_id[KEEP_W-1:0]), req_pri,
                           in_data_i.interruptible};
                idx_d   = count_q;
                state_d = ST_INS_CHK;
              end
            end
            MODE_WAKE_ONE: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
                state_d  = ST_RESP;
              end else begin
                mem_re  = 1'b1;  // head entry
                state_d = ST_W1_OUT;
              end
            end
            MODE_WAKE_ALL: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
                state_d  = ST_RESP;
              end else begin
                idx_d   = '0;
                state_d = ST_WA_RD;
              end
            end
            default: begin
              // unused mode: transaction taken, nothing happens
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_d       = '{status: status_q, woken_id: '0, woken_priority: '0,
                          woken_interruptible: 1'b0, last: 1'b1};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_INS_CHK: begin
        if (idx_q == '0) begin
          // reached the head: new entry becomes the head
          mem_we   = 1'b1;
          count_d  = count_q + CNT_W'(1);
          status_d = STATUS_QUEUED;
          state_d  = ST_RESP;
        end else begin
          offset  = idx_q - CNT_W'(1);
          mem_re  = 1'b1;
          state_d = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        mem_we = 1'b1;
        if (rd_lower) begin
          // move the lower priority entry one slot toward the tail
          mem_wdata = mem_rdata;
          idx_d     = idx_q - CNT_W'(1);
          state_d   = ST_INS_CHK;
        end else begin
          count_d  = count_q + CNT_W'(1);
          status_d = STATUS_QUEUED;
          state_d  = ST_RESP;
        end
      end

      ST_W1_OUT: begin
        offset = CNT_W'(1);
        if (out_free) begin
          out_d       = '{status: STATUS_WOKEN, woken_id: PORT_ID_W'(rd_id[KEEP_W-1:0]),
                          woken_priority: rd_pri, woken_interruptible: rd_flg,
                          last: 1'b1};
          out_valid_d = 1'b1;
          head_d      = phys_addr;
          count_d     = count_q - CNT_W'(1);
          state_d     = ST_IDLE;
        end
      end

      ST_WA_RD: begin
        mem_re  = 1'b1;
        state_d = ST_WA_OUT;
      end

      ST_WA_OUT: begin
        if (out_free) begin
          out_d       = '{status: STATUS_WOKEN, woken_id: PORT_ID_W'(rd_id[KEEP_W-1:0]),
                          woken_priority: rd_pri, woken_interruptible: rd_flg,
                          last: wa_last};
          out_valid_d = 1'b1;
          if (wa_last) begin
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = ST_WA_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and work registers, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    status_q <= status_d;
    new_q    <= new_d;
    out_q    <= out_d;
  end

  psq_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (phys_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (phys_addr),
    .rdata_o (mem_rdata)
  );

endmodule

/* sim/tb_priority_sleep_queue_top.sv */
// self-checking testbench for priority_sleep_queue_top
// depends on rtl/psq_pkg.sv and the top module; carries its own queue predictor
`timescale 1ns / 1ps

module tb_priority_sleep_queue_top;
  import psq_pkg::*;

  // random transactions that count toward the run length (mode 3 does not count)
  localparam int RANDOM_ITEMS = 250;
  // worst item is an insert shifting 15 entries back or a wake-all of
  // 16 results with the receiver stalling about half the time
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 100;

  logic     clk_i = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  psq_in_t  in_data = '0;
  logic     out_ready = 1'b0;
  logic     in_ready;
  logic     out_valid;
  psq_out_t out_data;

  priority_sleep_queue_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // transactions waiting to be driven, and results the queue still owes us
  psq_in_t  pending_reqs[$];
  psq_out_t results_due[$];

  // predictor state: sorted wait queue, head at slot 0
  logic [PORT_ID_W-1:0] slot_id[QUEUE_DEPTH];
  logic [PRI_W-1:0]     slot_pri[QUEUE_DEPTH];
  logic                 slot_flag[QUEUE_DEPTH];
  int                   slot_count = 0;

  // coverage tallies for the summary
  int n_queued = 0, n_full = 0, n_woken = 0, n_empty = 0, n_wake_all = 0, n_ignored = 0;

  int fail_count   = 0;
  int items_sent   = 0;
  int plan_total   = 1;
  int cycle_count  = 0;
  int results_seen = 0;

  // idle pattern: sender 25 / receiver 47, then swapped, then no idling
  int send_gap_pct, recv_stall_pct;
  assign send_gap_pct   = (items_sent < plan_total / 3)     ? 25 :
                          (items_sent < 2 * plan_total / 3) ? 47 : 0;
  assign recv_stall_pct = (items_sent < plan_total / 3)     ? 47 :
                          (items_sent < 2 * plan_total / 3) ? 25 : 0;

  function automatic psq_in_t make_req(logic [MODE_W-1:0] mode, logic [PORT_ID_W-1:0] id,
                                       logic [PRI_W-1:0] pri, logic flag);
    psq_in_t r;
    r.mode          = mode;
    r.waiter_id     = id;
    r.priority_req  = pri;
    r.interruptible = flag;
    return r;
  endfunction

  // apply one accepted transaction to the predicted queue and queue its results
  task automatic sleep_queue_apply(input psq_in_t req);
    psq_out_t             res;
    logic [PRI_W-1:0]     pri;
    logic [PORT_ID_W-1:0] id_kept;
    int                   ins_at;
    int                   i;
    res      = '0;
    res.last = 1'b1;
    case (req.mode)
      MODE_INSERT: begin
        pri     = (req.priority_req > MAX_PRIORITY) ? MAX_PRIORITY : req.priority_req;
        id_kept = req.waiter_id & PORT_ID_W'((64'd1 << ID_BITS) - 1);
        if (slot_count >= QUEUE_DEPTH) begin
          res.status = STATUS_FULL;
          n_full++;
        end else begin
          // new entry goes ahead of the first strictly lower priority
          ins_at = slot_count;
          for (i = slot_count - 1; i >= 0; i--) begin
            if (slot_pri[i] < pri) ins_at = i;
          end
          for (i = slot_count; i > ins_at; i--) begin
            slot_id[i]   = slot_id[i-1];
            slot_pri[i]  = slot_pri[i-1];
            slot_flag[i] = slot_flag[i-1];
          end
          slot_id[ins_at]   = id_kept;
          slot_pri[ins_at]  = pri;
          slot_flag[ins_at] = req.interruptible;
          slot_count++;
          res.status = STATUS_QUEUED;
          n_queued++;
        end
        results_due.push_back(res);
      end
      MODE_WAKE_ONE: begin
        if (slot_count == 0) begin
          res.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          res.status              = STATUS_WOKEN;
          res.woken_id            = slot_id[0];
          res.woken_priority      = slot_pri[0];
          res.woken_interruptible = slot_flag[0];
          for (i = 1; i < slot_count; i++) begin
            slot_id[i-1]   = slot_id[i];
            slot_pri[i-1]  = slot_pri[i];
            slot_flag[i-1] = slot_flag[i];
          end
          slot_count--;
          n_woken++;
        end
        results_due.push_back(res);
      end
      MODE_WAKE_ALL: begin
        if (slot_count == 0) begin
          res.status = STATUS_EMPTY;
          n_empty++;
          results_due.push_back(res);
        end else begin
          n_wake_all++;
          for (i = 0; i < slot_count; i++) begin
            res.status              = STATUS_WOKEN;
            res.woken_id            = slot_id[i];
            res.woken_priority      = slot_pri[i];
            res.woken_interruptible = slot_flag[i];
            res.last                = (i == slot_count - 1);
            results_due.push_back(res);
            n_woken++;
          end
          slot_count = 0;
        end
      end
      default: n_ignored++;  // mode 3: no result, no state change
    endcase
  endtask

  // driver: valid holds with a stable payload until the handshake completes
  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        sleep_queue_apply(in_data);
        items_sent <= items_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic match_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // monitor: every accepted result is checked against the oldest expectation
  psq_out_t want_res;
  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d id %0d",
                   $time, out_data.status, out_data.woken_id);
          fail_count++;
        end else begin
          want_res = results_due.pop_front();
          match_field("status", 8'(want_res.status), 8'(out_data.status));
          match_field("woken_id", 8'(want_res.woken_id), 8'(out_data.woken_id));
          match_field("woken_priority", 8'(want_res.woken_priority),
                      8'(out_data.woken_priority));
          match_field("woken_interruptible", 8'(want_res.woken_interruptible),
                      8'(out_data.woken_interruptible));
          match_field("last", 8'(want_res.last), 8'(out_data.last));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               results_due.size());
      $display("tb_priority_sleep_queue_top NOT OK");
      $finish;
    end
  end

  // stimulus, then drain and verdict
  int counted;
  int burst;
  int k;
  logic [MODE_W-1:0] rmode;
  logic [PRI_W-1:0]  rpri;
  initial begin
    // directed: fill the queue with field extremes, ties and out-of-range priorities
    for (k = 0; k < QUEUE_DEPTH; k++) begin
      case (k % 4)
        0:       rpri = 6'd0;
        1:       rpri = 6'd48;
        2:       rpri = 6'd63;  // saturates to 48, ties with the 48s
        default: rpri = 6'(49 + k);
      endcase
      pending_reqs.push_back(make_req(MODE_INSERT, 8'(k * 17), rpri, k[0]));
    end
    pending_reqs.push_back(make_req(MODE_INSERT, 8'hff, 6'h3f, 1'b1));  // queue full
    pending_reqs.push_back(make_req(MODE_WAKE_ONE, 8'h00, 6'h00, 1'b0));
    pending_reqs.push_back(make_req(MODE_WAKE_ALL, 8'hff, 6'h3f, 1'b1));
    pending_reqs.push_back(make_req(MODE_WAKE_ONE, 8'hff, 6'h3f, 1'b1));  // empty
    pending_reqs.push_back(make_req(MODE_WAKE_ALL, 8'h00, 6'h00, 1'b0));  // empty
    pending_reqs.push_back(make_req(MODE_RESERVED, 8'ha5, 6'h2a, 1'b1));  // ignored mode
    pending_reqs.push_back(make_req(MODE_INSERT, 8'h5a, 6'd1, 1'b0));
    pending_reqs.push_back(make_req(MODE_WAKE_ALL, 8'h00, 6'h00, 1'b0));  // single entry

    // random: mostly insert bursts followed by wakes, some loose noise
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 85) begin
        burst = $urandom_range(1, 18);
        repeat (burst) begin
          // half from a narrow band near the top to force ties and saturation
          rpri = $urandom_range(1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(44, 50));
          pending_reqs.push_back(make_req(MODE_INSERT, 8'($urandom_range(0, 255)), rpri,
                                          1'($urandom_range(0, 1))));
        end
        counted += burst;
        burst = $urandom_range(0, 5);
        repeat (burst) begin
          pending_reqs.push_back(make_req(MODE_WAKE_ONE, 8'($urandom_range(0, 255)),
                                          6'($urandom_range(0, 63)), 1'($urandom_range(0, 1))));
        end
        counted += burst;
        if ($urandom_range(99) < 40) begin
          pending_reqs.push_back(make_req(MODE_WAKE_ALL, 8'($urandom_range(0, 255)),
                                          6'($urandom_range(0, 63)), 1'($urandom_range(0, 1))));
          counted++;
        end
      end else begin
        rmode = 2'($urandom_range(0, 3));
        pending_reqs.push_back(make_req(rmode, 8'($urandom_range(0, 255)),
                                        6'($urandom_range(0, 63)), 1'($urandom_range(0, 1))));
        if (rmode != MODE_RESERVED) counted++;
      end
    end
    plan_total = pending_reqs.size();

    // single reset at the start of the run
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d transactions, %0d results: %0d queued, %0d full, %0d woken,",
             items_sent, results_seen, n_queued, n_full, n_woken);
    $display("  %0d empty, %0d wake-all bursts, %0d ignored mode-3 transactions",
             n_empty, n_wake_all, n_ignored);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("tb_priority_sleep_queue_top OK");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, results_due.size());
      $display("tb_priority_sleep_queue_top NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/psq_pkg.sv
rtl/psq_store.sv
rtl/priority_sleep_queue_top.sv
sim/tb_priority_sleep_queue_top.sv
